// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared macros for concurrent assertions in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT(lbl, prop, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, prop, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) not (prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT(lbl, prop, clk, rstn)
`define ASSERT_NEVER(lbl, prop, clk, rstn)
`endif
`endif

// ----- hw/rtl/pws_pkg.sv -----
// ----------------------------------------------------------------------------
// pws_pkg
// Types, constants and helpers shared by the weight matrix scanner.
// ----------------------------------------------------------------------------
package pws_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int COL_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W      = $clog2(MAX_WINDOW + 1);

  localparam int Q_W        = 17;
  localparam logic [Q_W-1:0] Q_ONE = 17'h10000;
  localparam int PROD_W     = 2 * Q_W;
  localparam int Q_FRAC     = 16;

  localparam int CODE_W     = 3;
  localparam logic [CODE_W-1:0] CODE_A     = 3'd0;
  localparam logic [CODE_W-1:0] CODE_C     = 3'd1;
  localparam logic [CODE_W-1:0] CODE_G     = 3'd2;
  localparam logic [CODE_W-1:0] CODE_T     = 3'd3;
  localparam logic [CODE_W-1:0] CODE_OTHER = 3'd4;

  localparam int OFFS_W     = 32;
  localparam int BASES_W    = 48;
  localparam int BASES_COLS = BASES_W / CODE_W;
  localparam int PACK_COLS  = (MAX_WINDOW < BASES_COLS) ? MAX_WINDOW : BASES_COLS;

  localparam int WL_W       = 5;
  localparam int CUT_W      = 17;
  localparam logic [WL_W-1:0] WL_RESET = 5'd16;

  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_SCORE_CUTOFF  = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CHAR = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [7:0]       seq_char;
    logic             new_sequence;
    logic [3:0]       weight_column;
    logic [1:0]       weight_base;
    logic [Q_W-1:0]   weight_value;
  } pws_in_t;

  typedef struct packed {
    logic [OFFS_W-1:0]  start_offset;
    logic [Q_W-1:0]     window_score;
    logic [BASES_W-1:0] window_bases;
  } pws_out_t;

  typedef logic [MAX_WINDOW-1:0][CODE_W-1:0] pws_codes_t;

  typedef struct packed {
    logic           vld;
    logic [Q_W-1:0] prod;
  } pws_tok_t;

  typedef struct packed {
    logic           en;
    logic [1:0]     base;
    logic [Q_W-1:0] value;
  } pws_wr_t;

  typedef struct packed {
    logic           en;
    logic [3:0]     column;
    logic [1:0]     base;
    logic [Q_W-1:0] value;
  } pws_load_t;

  function automatic logic [CODE_W-1:0] char_code(input logic [7:0] c);
    logic [CODE_W-1:0] code;
    case (c) inside
      "A", "a": code = CODE_A;
      "C", "c": code = CODE_C;
      "G", "g": code = CODE_G;
      "T", "t": code = CODE_T;
      default:  code = CODE_OTHER;
    endcase
    return code;
  endfunction

endpackage

// ----- hw/rtl/pwm_window_scan.sv -----
// ----------------------------------------------------------------------------
// pwm_window_scan
// Position weight matrix scanner over a DNA character stream.
// ----------------------------------------------------------------------------
// A weight load, and a character that does not yet complete a window, leave
// the block idle and ready. A character that completes a window of L columns
// keeps the block busy: the request registers the window, the running product
// walks through a row of L multiplier cells, one column per cycle, the score
// is registered, and ST_EMIT compares it with the cutoff and loads the output
// register. A window that meets the cutoff is presented with its start offset,
// score and packed bases; a further report waits while the previous one has
// not been taken, and the block takes no request meanwhile.
module pwm_window_scan (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pws_pkg::pws_in_t                    in_req_i,

  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pws_pkg::pws_out_t                   out_rsp_o,

  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pws_pkg::ADDR_W-1:0]          paddr,
  input  logic [pws_pkg::DATA_W-1:0]          pwdata,
  output logic [pws_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);

`include "assert_macros.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e                                 state_q;
  logic [pws_pkg::WL_W-1:0]               wl_q;
  logic [pws_pkg::CUT_W-1:0]              cutoff_q;
  logic                                   cfg_we;
  logic [pws_pkg::REG_IDX_W-1:0]          reg_idx;

  logic                                   in_acc;
  logic                                   char_acc;
  logic [pws_pkg::LEN_W-1:0]              len;
  logic [pws_pkg::COL_W-1:0]              last_col;

  pws_pkg::pws_codes_t                    hist_q, hist_d;
  pws_pkg::pws_codes_t                    codes_q, codes_d;
  logic [pws_pkg::OFFS_W-1:0]             seen_q, seen_d, seen_base;
  logic [pws_pkg::OFFS_W-1:0]             offset_q;
  logic [pws_pkg::BASES_W-1:0]            bases_q, bases_d;
  logic [pws_pkg::Q_W-1:0]                score_q;
  logic                                   start_q;
  logic                                   win_full;

  pws_pkg::pws_load_t                     load;
  pws_pkg::pws_tok_t                      done;

  logic                                   out_valid_q;
  pws_pkg::pws_out_t                      out_q;
  logic                                   out_free;
  logic                                   emit_stall;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q     <= pws_pkg::WL_RESET;
      cutoff_q <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        pws_pkg::REG_WINDOW_LENGTH: wl_q     <= pwdata[pws_pkg::WL_W-1:0];
        pws_pkg::REG_SCORE_CUTOFF:  cutoff_q <= pwdata[pws_pkg::CUT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pws_pkg::REG_WINDOW_LENGTH: prdata = pws_pkg::DATA_W'(wl_q);
      pws_pkg::REG_SCORE_CUTOFF:  prdata = pws_pkg::DATA_W'(cutoff_q);
    endcase
  end

  always_comb begin
    if (wl_q == '0) begin
      len = pws_pkg::LEN_W'(1);
    end else if (32'(wl_q) > 32'(pws_pkg::MAX_WINDOW)) begin
      len = pws_pkg::LEN_W'(pws_pkg::MAX_WINDOW);
    end else begin
      len = pws_pkg::LEN_W'(wl_q);
    end
  end

  assign last_col = pws_pkg::COL_W'(len - pws_pkg::LEN_W'(1));

  // Request intake.
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign char_acc   = in_acc && (in_req_i.opcode == pws_pkg::OP_CHAR);

  assign load.en     = in_acc && (in_req_i.opcode == pws_pkg::OP_LOAD);
  assign load.column = in_req_i.weight_column;
  assign load.base   = in_req_i.weight_base;
  assign load.value  = (in_req_i.weight_value > pws_pkg::Q_ONE) ? pws_pkg::Q_ONE
                                                                 : in_req_i.weight_value;

  always_comb begin
    seen_base = in_req_i.new_sequence ? '0 : seen_q;
    seen_d    = (&seen_base) ? seen_base : seen_base + 1'b1;
    for (int i = 0; i < pws_pkg::MAX_WINDOW; i++) begin
      if (i == 0) begin
        hist_d[i] = pws_pkg::char_code(in_req_i.seq_char);
      end else begin
        hist_d[i] = in_req_i.new_sequence ? '0 : hist_q[i-1];
      end
    end
  end

  // Column i of the window holds the character L-1-i places back.
  always_comb begin
    codes_d = '0;
    bases_d = '0;
    for (int i = 0; i < pws_pkg::MAX_WINDOW; i++) begin
      if (32'(i) < 32'(len)) begin
        codes_d[i] = hist_d[pws_pkg::COL_W'(len - pws_pkg::LEN_W'(1) - pws_pkg::LEN_W'(i))];
      end else begin
        codes_d[i] = pws_pkg::CODE_OTHER;
      end
    end
    for (int i = 0; i < pws_pkg::PACK_COLS; i++) begin
      if (32'(i) < 32'(len)) begin
        bases_d[pws_pkg::CODE_W*i +: pws_pkg::CODE_W] = codes_d[i];
      end
    end
  end

  assign win_full = (seen_d >= pws_pkg::OFFS_W'(len));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= '0;
      seen_q  <= '0;
      start_q <= 1'b0;
    end else begin
      start_q <= char_acc && win_full;
      if (char_acc) begin
        hist_q <= hist_d;
        seen_q <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_acc) begin
      codes_q  <= codes_d;
      bases_q  <= bases_d;
      offset_q <= seen_d - pws_pkg::OFFS_W'(len);
    end
    if (done.vld) begin
      score_q <= done.prod;
    end
  end

  pws_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .codes_i    (codes_q),
    .load_i     (load),
    .last_col_i (last_col),
    .done_o     (done)
  );

  // Control and output register.
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit_stall = (state_q == ST_EMIT) && (score_q >= cutoff_q) && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (char_acc && win_full) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (done.vld) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (score_q < cutoff_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            state_q            <= ST_IDLE;
            out_valid_q        <= 1'b1;
            out_q.start_offset <= offset_q;
            out_q.window_score <= score_q;
            out_q.window_bases <= bases_q;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `ASSERT(a_done_in_scan, done.vld |-> state_q == ST_SCAN, clk_i, rst_ni)
  `ASSERT(a_emit_waits, emit_stall |=> state_q == ST_EMIT, clk_i, rst_ni)
  `ASSERT(a_score_range, out_valid_o |-> out_rsp_o.window_score <= pws_pkg::Q_ONE, clk_i, rst_ni)
  `ASSERT_NEVER(a_start_busy, start_q && state_q != ST_SCAN, clk_i, rst_ni)

endmodule

// ----- hw/rtl/pws_cell.sv -----
// ----------------------------------------------------------------------------
// pws_cell
// One matrix column: holds the four base weights of the column and multiplies
// the passing running product by its character's weight, if A, C, G or T.
// ----------------------------------------------------------------------------
module pws_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pws_pkg::pws_wr_t                    wr_i,
  input  logic [pws_pkg::CODE_W-1:0]          code_i,
  input  pws_pkg::pws_tok_t                   tok_i,
  output pws_pkg::pws_tok_t                   tok_o
);

  logic [pws_pkg::Q_W-1:0]    w_q [4];
  logic [pws_pkg::PROD_W-1:0] prod_full;
  logic [pws_pkg::Q_W-1:0]    prod_d;
  logic [pws_pkg::Q_W-1:0]    prod_q;
  logic                       vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      w_q[wr_i.base] <= wr_i.value;
    end
  end

  assign prod_full = pws_pkg::PROD_W'(tok_i.prod) * pws_pkg::PROD_W'(w_q[code_i[1:0]]);

  always_comb begin
    if (code_i < pws_pkg::CODE_OTHER) begin
      prod_d = prod_full[pws_pkg::Q_FRAC +: pws_pkg::Q_W];
    end else begin
      prod_d = tok_i.prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign tok_o.vld  = vld_q;
  assign tok_o.prod = prod_q;

endmodule

// ----- hw/rtl/pws_chain.sv -----
// ----------------------------------------------------------------------------
// pws_chain
// Row of column cells. A product token enters at column 0 and moves one
// column per cycle; the token leaving the last active column is the score.
// ----------------------------------------------------------------------------
module pws_chain (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  pws_pkg::pws_codes_t               codes_i,
  input  pws_pkg::pws_load_t                load_i,
  input  logic [pws_pkg::COL_W-1:0]         last_col_i,
  output pws_pkg::pws_tok_t                 done_o
);

  pws_pkg::pws_tok_t tok_in  [pws_pkg::MAX_WINDOW];
  pws_pkg::pws_tok_t tok_out [pws_pkg::MAX_WINDOW];
  pws_pkg::pws_wr_t  wr      [pws_pkg::MAX_WINDOW];

  for (genvar i = 0; i < pws_pkg::MAX_WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i].vld  = start_i;
      assign tok_in[i].prod = pws_pkg::Q_ONE;
    end else begin : g_link
      assign tok_in[i] = tok_out[i-1];
    end

    assign wr[i].en    = load_i.en && (32'(load_i.column) == 32'(i));
    assign wr[i].base  = load_i.base;
    assign wr[i].value = load_i.value;

    pws_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr[i]),
      .code_i (codes_i[i]),
      .tok_i  (tok_in[i]),
      .tok_o  (tok_out[i])
    );
  end

  assign done_o = tok_out[last_col_i];

endmodule
